// File: rtl/core/timestamp_delta_log2_histogram_unit_assert.svh
// Assertion macros for the log2 delta histogram unit checks.
`ifndef TIMESTAMP_DELTA_LOG2_HISTOGRAM_UNIT_ASSERT_SVH
`define TIMESTAMP_DELTA_LOG2_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TDLH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdlh check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TDLH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdlh check failed: next-cycle implication");

`endif

// File: rtl/core/tdlh_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package tdlh_pkg;

	localparam int unsigned BIN_COUNT = 32;
	localparam int unsigned BIN_W     = $clog2(BIN_COUNT);
	localparam int unsigned CNT_W     = 48;
	localparam int unsigned TS_W      = 64;
	localparam int unsigned DUR_W     = 12;
	localparam int unsigned LIMIT_W   = 32;
	localparam int unsigned MUL_W     = 24;
	localparam int unsigned PROD_W    = TS_W + MUL_W;
	localparam int unsigned REM_W     = CNT_W + 1;
	localparam int unsigned ITER_W    = $clog2(PROD_W);
	localparam int unsigned WARP_W    = 32;
	localparam int unsigned PCT_W     = 24;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned ADDR_W    = 2;
	localparam int unsigned APB_W     = 32;

	localparam logic [DUR_W-1:0]   DUR_RESET       = 12'd3;
	localparam logic [LIMIT_W-1:0] US_PER_S        = 32'd1000000;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET     = LIMIT_W'(32'(DUR_RESET) * US_PER_S);
	localparam logic [MUL_W-1:0]   CENTI_NS_PER_US = 24'd100000;
	localparam logic [MUL_W-1:0]   PCT_SCALE       = 24'd10000000;

	localparam logic FUNC_START  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic [KIND_W-1:0] KIND_WARP    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BIN     = 2'd2;

	localparam logic [ADDR_W-1:0] REG_DURATION = 2'd0;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // take input transaction
		logic start;     // begin a run
		logic stop;      // end the run
		logic eval;      // latch delta, elapsed, advance previous time
		logic look;      // latch bin index, read its counter
		logic inc;       // write back incremented counter
		logic top;       // latch highest nonzero bin
		logic md_sum;    // launch per-loop division
		logic md_bin;    // launch bin percentage division
		logic bin_rd;    // read counter of current report bin
		logic bin_dec;   // step to next lower bin
		logic ld_warp;
		logic ld_sum;
		logic ld_bin;
	} tdlh_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic func_start;
		logic running;
		logic neg;
		logic done;
		logic md_busy;
		logic out_free;
		logic cur_zero;
	} tdlh_sts_t;

endpackage

// File: rtl/core/tdlh_cfg.sv
// APB register block: run duration and its microsecond limit.
module tdlh_cfg import tdlh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	output logic [LIMIT_W-1:0] limit_us
);

	logic [DUR_W-1:0]   dur_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               wr_en;

	assign wr_en = psel && penable && pwrite && (paddr == REG_DURATION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q   <= DUR_RESET;
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			dur_q   <= pwdata[DUR_W-1:0];
			limit_q <= LIMIT_W'(pwdata[DUR_W-1:0]) * US_PER_S;
		end
	end

	assign prdata   = (paddr == REG_DURATION) ? APB_W'(dur_q) : '0;
	assign pready   = 1'b1;
	assign limit_us = limit_q;

endmodule

// File: rtl/core/tdlh_muldiv.sv
// Sequential (a * m) / d with round half up, saturated to 64 bits.
module tdlh_muldiv import tdlh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [TS_W-1:0]  a,
	input  logic [MUL_W-1:0] m,
	input  logic [CNT_W-1:0] d,
	output logic             busy,
	output logic [TS_W-1:0]  q
);

	typedef enum logic [3:0] {
		MD_IDLE = 4'b0001,
		MD_MUL  = 4'b0010,
		MD_DIV  = 4'b0100,
		MD_RND  = 4'b1000
	} md_state_t;

	md_state_t          state_q;
	logic [ITER_W-1:0]  iter_q;
	logic [TS_W-1:0]    a_q;
	logic [MUL_W-1:0]   m_q;
	logic [CNT_W-1:0]   d_q;
	logic [PROD_W-1:0]  acc_q;
	logic [REM_W-1:0]   rem_q;
	logic [TS_W-1:0]    quo_q;
	logic               ovf_q;
	logic [TS_W-1:0]    q_q;

	logic [PROD_W-1:0]  addend;
	logic [REM_W-1:0]   rem_sh;
	logic [REM_W-1:0]   rem_dif;
	logic               ge;
	logic               half_up;

	assign addend  = m_q[MUL_W-1] ? PROD_W'(a_q) : '0;
	assign rem_sh  = {rem_q[REM_W-2:0], acc_q[PROD_W-1]};
	assign ge      = rem_sh >= {1'b0, d_q};
	assign rem_dif = rem_sh - {1'b0, d_q};
	// 2*rem >= d
	assign half_up = {rem_q, 1'b0} >= {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				MD_IDLE: begin
					if (start) begin
						state_q <= MD_MUL;
						iter_q  <= ITER_W'(MUL_W - 1);
					end
				end
				MD_MUL: begin
					if (iter_q == '0) begin
						state_q <= MD_DIV;
						iter_q  <= ITER_W'(PROD_W - 1);
					end else begin
						iter_q <= iter_q - 1'b1;
					end
				end
				MD_DIV: begin
					if (iter_q == '0) begin
						state_q <= MD_RND;
					end else begin
						iter_q <= iter_q - 1'b1;
					end
				end
				MD_RND: begin
					state_q <= MD_IDLE;
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			MD_IDLE: begin
				if (start) begin
					a_q   <= a;
					m_q   <= m;
					d_q   <= d;
					acc_q <= '0;
				end
			end
			MD_MUL: begin
				// shift-add, multiplier MSB first
				acc_q <= (acc_q << 1) + addend;
				m_q   <= m_q << 1;
				if (iter_q == '0) begin
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			MD_DIV: begin
				// restoring division, one quotient bit per cycle
				rem_q <= ge ? rem_dif : rem_sh;
				acc_q <= acc_q << 1;
				quo_q <= {quo_q[TS_W-2:0], ge};
				ovf_q <= ovf_q | quo_q[TS_W-1];
			end
			MD_RND: begin
				q_q <= (ovf_q || (half_up && (&quo_q))) ? '1 : quo_q + TS_W'(half_up);
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != MD_IDLE);
	assign q    = q_q;

endmodule

// File: rtl/core/tdlh_ctrl.sv
// Controller: sequences sample handling and the end-of-run report.
module tdlh_ctrl import tdlh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  tdlh_sts_t sts,
	output tdlh_cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_EVAL     = 9'b000000010,
		S_LOOK     = 9'b000000100,
		S_INC      = 9'b000001000,
		S_SUM      = 9'b000010000,
		S_SUM_WAIT = 9'b000100000,
		S_BIN_RD   = 9'b001000000,
		S_BIN_CALC = 9'b010000000,
		S_BIN_WAIT = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EVAL;
				end
			end
			S_EVAL: begin
				priority if (sts.func_start) begin
					cmd.start = 1'b1;
					state_nxt = S_IDLE;
				end else if (!sts.running) begin
					state_nxt = S_IDLE;
				end else if (sts.neg) begin
					if (sts.out_free) begin
						cmd.ld_warp = 1'b1;
						cmd.stop    = 1'b1;
						state_nxt   = S_IDLE;
					end
				end else begin
					cmd.eval  = 1'b1;
					state_nxt = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look  = 1'b1;
				state_nxt = S_INC;
			end
			S_INC: begin
				cmd.inc = 1'b1;
				if (sts.done) begin
					cmd.stop  = 1'b1;
					state_nxt = S_SUM;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_SUM: begin
				cmd.top    = 1'b1;
				cmd.md_sum = 1'b1;
				state_nxt  = S_SUM_WAIT;
			end
			S_SUM_WAIT: begin
				if (!sts.md_busy && sts.out_free) begin
					cmd.ld_sum = 1'b1;
					state_nxt  = S_BIN_RD;
				end
			end
			S_BIN_RD: begin
				cmd.bin_rd = 1'b1;
				state_nxt  = S_BIN_CALC;
			end
			S_BIN_CALC: begin
				cmd.md_bin = 1'b1;
				state_nxt  = S_BIN_WAIT;
			end
			S_BIN_WAIT: begin
				if (!sts.md_busy && sts.out_free) begin
					cmd.ld_bin = 1'b1;
					if (sts.cur_zero) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.bin_dec = 1'b1;
						state_nxt   = S_BIN_RD;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// File: rtl/core/tdlh_dp.sv
// Datapath: timestamps, counters, bin memory, divider and output register.
module tdlh_dp import tdlh_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tdlh_cmd_t                cmd,
	output tdlh_sts_t                sts,
	input  logic [LIMIT_W-1:0]       limit_us,
	input  logic                     func,
	input  logic [TS_W-1:0]          timestamp_us,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic [KIND_W-1:0]        kind,
	output logic signed [WARP_W-1:0] warp_us,
	output logic [CNT_W-1:0]         total_loops,
	output logic [TS_W-1:0]          per_loop_centi_ns,
	output logic [BIN_W-1:0]         bin_exponent,
	output logic [CNT_W-1:0]         bin_count,
	output logic [PCT_W-1:0]         percent_e5,
	output logic                     last
);

	function automatic logic [BIN_W-1:0] bit_len(input logic [TS_W-1:0] v);
		logic [BIN_W-1:0] n;
		n = '0;
		for (int i = 0; i < BIN_COUNT - 1; i++) begin
			if (v[i]) n = BIN_W'(i + 1);
		end
		if (|(v >> (BIN_COUNT - 1))) n = BIN_W'(BIN_COUNT - 1);
		return n;
	endfunction

	logic                     func_q;
	logic [TS_W-1:0]          ts_q;
	logic [TS_W-1:0]          start_q;
	logic [TS_W-1:0]          prev_q;
	logic [TS_W-1:0]          delta_q;
	logic [TS_W-1:0]          elapsed_q;
	logic                     running_q;
	logic [CNT_W-1:0]         count_q;
	logic [BIN_COUNT-1:0]     valid_q;
	logic [BIN_W-1:0]         bin_q;
	logic [BIN_W-1:0]         cur_q;
	logic [CNT_W-1:0]         rd_q;
	logic [CNT_W-1:0]         bincnt_q;
	logic [CNT_W-1:0]         bin_mem [BIN_COUNT];

	logic                     out_valid_q;
	logic [KIND_W-1:0]        kind_q;
	logic signed [WARP_W-1:0] warp_q;
	logic [CNT_W-1:0]         total_q;
	logic [TS_W-1:0]          per_q;
	logic [BIN_W-1:0]         exp_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [PCT_W-1:0]         pct_q;
	logic                     last_q;

	logic [TS_W-1:0]          delta_now;
	logic [TS_W-1:0]          elapsed_now;
	logic [WARP_W-1:0]        warp_val;
	logic [BIN_W-1:0]         look_idx;
	logic [BIN_W-1:0]         top_idx;
	logic [BIN_W-1:0]         rd_addr;
	logic [CNT_W-1:0]         inc_val;
	logic [CNT_W-1:0]         bin_val;
	logic [PCT_W-1:0]         pct_val;
	logic                     md_start;
	logic [TS_W-1:0]          md_a;
	logic [MUL_W-1:0]         md_m;
	logic                     md_busy;
	logic [TS_W-1:0]          md_q;

	assign delta_now   = ts_q - prev_q;
	assign elapsed_now = ts_q - start_q;
	// delta below -2^31 saturates to the most negative 32-bit value
	assign warp_val = (&delta_now[TS_W-1:WARP_W-1]) ? delta_now[WARP_W-1:0]
	                                                : {1'b1, {(WARP_W-1){1'b0}}};
	assign look_idx = bit_len(delta_q);

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < BIN_COUNT; i++) begin
			if (valid_q[i]) top_idx = BIN_W'(i);
		end
	end

	// an unwritten bin reads as zero
	assign inc_val = !valid_q[bin_q] ? CNT_W'(1) : ((&rd_q) ? rd_q : rd_q + 1'b1);
	assign bin_val = valid_q[cur_q] ? rd_q : '0;
	assign pct_val = (md_q > TS_W'(PCT_SCALE)) ? PCT_SCALE : md_q[PCT_W-1:0];
	assign rd_addr = cmd.look ? look_idx : cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				running_q <= 1'b1;
				valid_q   <= '0;
				count_q   <= '0;
			end
			if (cmd.stop) running_q <= 1'b0;
			if (cmd.inc) begin
				valid_q[bin_q] <= 1'b1;
				if (!(&count_q)) count_q <= count_q + 1'b1;
			end
			if (cmd.ld_warp || cmd.ld_sum || cmd.ld_bin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.inc) bin_mem[bin_q] <= inc_val;
		if (cmd.look || cmd.bin_rd) rd_q <= bin_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			ts_q   <= timestamp_us;
		end
		if (cmd.start) begin
			start_q <= ts_q;
			prev_q  <= ts_q;
		end
		if (cmd.eval) begin
			prev_q    <= ts_q;
			delta_q   <= delta_now;
			elapsed_q <= elapsed_now;
		end
		if (cmd.look) bin_q <= look_idx;
		if (cmd.top) begin
			cur_q <= top_idx;
		end else if (cmd.bin_dec) begin
			cur_q <= cur_q - 1'b1;
		end
		if (cmd.md_bin) bincnt_q <= bin_val;

		if (cmd.ld_warp || cmd.ld_sum || cmd.ld_bin) begin
			priority if (cmd.ld_warp) begin
				kind_q  <= KIND_WARP;
				warp_q  <= warp_val;
				total_q <= '0;
				per_q   <= '0;
				exp_q   <= '0;
				cnt_q   <= '0;
				pct_q   <= '0;
				last_q  <= 1'b1;
			end else if (cmd.ld_sum) begin
				kind_q  <= KIND_SUMMARY;
				warp_q  <= '0;
				total_q <= count_q;
				per_q   <= md_q;
				exp_q   <= '0;
				cnt_q   <= '0;
				pct_q   <= '0;
				last_q  <= 1'b0;
			end else begin
				kind_q  <= KIND_BIN;
				warp_q  <= '0;
				total_q <= '0;
				per_q   <= '0;
				exp_q   <= cur_q;
				cnt_q   <= bincnt_q;
				pct_q   <= pct_val;
				last_q  <= (cur_q == '0);
			end
		end
	end

	assign md_start = cmd.md_sum || cmd.md_bin;
	assign md_a     = cmd.md_bin ? TS_W'(bin_val) : elapsed_q;
	assign md_m     = cmd.md_bin ? PCT_SCALE : CENTI_NS_PER_US;

	tdlh_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a      (md_a),
		.m      (md_m),
		.d      (count_q),
		.busy   (md_busy),
		.q      (md_q)
	);

	assign sts.func_start = (func_q == FUNC_START);
	assign sts.running    = running_q;
	assign sts.neg        = delta_now[TS_W-1];
	assign sts.done       = (elapsed_q >= TS_W'(limit_us));
	assign sts.md_busy    = md_busy;
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.cur_zero   = (cur_q == '0);

	assign out_valid         = out_valid_q;
	assign kind              = kind_q;
	assign warp_us           = warp_q;
	assign total_loops       = total_q;
	assign per_loop_centi_ns = per_q;
	assign bin_exponent      = exp_q;
	assign bin_count         = cnt_q;
	assign percent_e5        = pct_q;
	assign last              = last_q;

endmodule

// File: rtl/core/timestamp_delta_log2_histogram_unit.sv
// Top level of the log2 timestamp-delta histogram unit.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  input    | in_valid / in_stall | func, timestamp_us
//  output   | out_valid/out_stall | kind, warp_us, total_loops, per_loop_centi_ns,
//           |                     | bin_exponent, bin_count, percent_e5, last
//  config   | APB psel/penable    | paddr, pwdata, prdata (duration_seconds at 0x0)
//
// Steps: a start, an ignored sample or a time warp is captured and evaluated, a
//   counted sample goes through capture, delta, bin memory read and write back;
//   the next input is taken when the last one is done.
// A run-ending sample adds a report on the shared multiply-divide unit, one
//   division for the summary and one per bin line, all before the next input
//   transaction.
// Reset clears control state and bin valid flags; the bin memory is not swept.
// A stalled output holds its transaction; the controller waits for the slot.
module timestamp_delta_log2_histogram_unit import tdlh_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     func,
	input  logic [TS_W-1:0]          timestamp_us,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [KIND_W-1:0]        kind,
	output logic signed [WARP_W-1:0] warp_us,
	output logic [CNT_W-1:0]         total_loops,
	output logic [TS_W-1:0]          per_loop_centi_ns,
	output logic [BIN_W-1:0]         bin_exponent,
	output logic [CNT_W-1:0]         bin_count,
	output logic [PCT_W-1:0]         percent_e5,
	output logic                     last,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [APB_W-1:0]         pwdata,
	output logic [APB_W-1:0]         prdata,
	output logic                     pready
);

	tdlh_cmd_t          cmd;
	tdlh_sts_t          sts;
	logic [LIMIT_W-1:0] limit_us;

	// Duration register; also keeps duration * 1e6 so the datapath only compares.
	tdlh_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.limit_us (limit_us)
	);

	// Controller: one transaction at a time, then the report if the run ended.
	tdlh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: run state, 32-entry bin counter memory with valid flags
	// (cleared at once on start), divider and the output register.
	tdlh_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.limit_us          (limit_us),
		.func              (func),
		.timestamp_us      (timestamp_us),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.kind              (kind),
		.warp_us           (warp_us),
		.total_loops       (total_loops),
		.per_loop_centi_ns (per_loop_centi_ns),
		.bin_exponent      (bin_exponent),
		.bin_count         (bin_count),
		.percent_e5        (percent_e5),
		.last              (last)
	);

endmodule

// File: rtl/core/tdlh_checker.sv
// Port-level checker for the histogram unit, bound to the top level.
`include "timestamp_delta_log2_histogram_unit_assert.svh"

module tdlh_checker import tdlh_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [KIND_W-1:0]        kind,
	input logic [CNT_W-1:0]         total_loops,
	input logic [BIN_W-1:0]         bin_exponent,
	input logic [CNT_W-1:0]         bin_count,
	input logic [PCT_W-1:0]         percent_e5,
	input logic                     last
);

	// held result keeps its payload
	`TDLH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(last) && $stable(bin_count))
	// one transaction in flight: busy right after an accept
	`TDLH_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall)
	// warp ends the result run and carries no counts
	`TDLH_ASSERT_NOW(a_warp_last, out_valid && (kind == KIND_WARP), last && (total_loops == '0) && (bin_count == '0))
	// summary never closes a run and always has samples
	`TDLH_ASSERT_NOW(a_sum_shape, out_valid && (kind == KIND_SUMMARY), !last && (total_loops != '0))
	// bin lines end at bin 0, share bounded
	`TDLH_ASSERT_NOW(a_bin_shape, out_valid && (kind == KIND_BIN), (last == (bin_exponent == '0)) && (percent_e5 <= PCT_SCALE))

endmodule

bind timestamp_delta_log2_histogram_unit tdlh_checker u_tdlh_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the log2 timestamp-delta histogram unit.
`timescale 1ns / 100ps

module testbench;
	import tdlh_pkg::*;

	localparam int unsigned CLK_HALF     = 6;
	localparam int unsigned RESET_CYCLES = 5;
	// Leave ample room after a start or a sample before a register write.
	localparam int unsigned DRAIN_CYCLES = 32;
	localparam int unsigned PHASE_ITEMS  = 27;
	// Worst case: every transaction ends a run with 33 report lines, each waiting on a
	// division, plus long output stalls and input gaps. Taken several times over.
	localparam longint unsigned CYCLE_LIMIT = 64'd5_000_000;
	localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

	// One result transaction, as the predictor builds it.
	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [WARP_W-1:0] warp;
		logic [CNT_W-1:0]         loops;
		logic [TS_W-1:0]          per_loop;
		logic [BIN_W-1:0]         exponent;
		logic [CNT_W-1:0]         count;
		logic [PCT_W-1:0]         pct;
		logic                     last;
	} report_line_t;

	// How a directed row is checked: by the predictor, or by a value typed in.
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_WARP
	} row_mode_t;

	typedef struct packed {
		logic            fn;
		logic [TS_W-1:0] ts;
		logic            typed;
		logic            has_line;
		report_line_t    line;
	} stim_row_t;

	// DUT ports
	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     func = 1'b0;
	logic [TS_W-1:0]          timestamp_us = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [KIND_W-1:0]        kind;
	logic signed [WARP_W-1:0] warp_us;
	logic [CNT_W-1:0]         total_loops;
	logic [TS_W-1:0]          per_loop_centi_ns;
	logic [BIN_W-1:0]         bin_exponent;
	logic [CNT_W-1:0]         bin_count;
	logic [PCT_W-1:0]         percent_e5;
	logic                     last;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [APB_W-1:0]         pwdata = '0;
	logic [APB_W-1:0]         prdata;
	logic                     pready;

	// Histogram predictor state and its copy of the duration register.
	logic [DUR_W-1:0] cfg_duration = DUR_RESET;
	logic             run_active = 1'b0;
	logic [TS_W-1:0]  run_start = '0;
	logic [TS_W-1:0]  prev_ts = '0;
	logic [CNT_W-1:0] loop_total = '0;
	logic [CNT_W-1:0] bin_tally [BIN_COUNT] = '{default: '0};

	report_line_t fresh_lines[$];    // lines caused by the latest transaction
	report_line_t pending_lines[$];  // lines still owed by the DUT, oldest first
	stim_row_t    directed_rows[$];

	int              mismatch_count = 0;
	int              lines_checked = 0;
	int              item_seq = 0;
	int              reports_seen = 0;
	int              warps_seen = 0;
	int              stall_left = 0;
	int              stall_tick = 0;
	longint unsigned cycle_count = 0;

	timestamp_delta_log2_histogram_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.func              (func),
		.timestamp_us      (timestamp_us),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.kind              (kind),
		.warp_us           (warp_us),
		.total_loops       (total_loops),
		.per_loop_centi_ns (per_loop_centi_ns),
		.bin_exponent      (bin_exponent),
		.bin_count         (bin_count),
		.percent_e5        (percent_e5),
		.last              (last),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int bit_length(input logic [63:0] v);
		int k, n;
		n = 0;
		for (k = 0; k < 64; k++)
			if (v[k]) n = k + 1;
		return n;
	endfunction

	// Random value of exactly b bits (top bit set), zero for b == 0.
	function automatic logic [63:0] sized_value(input int b);
		if (b == 0) return '0;
		return (rand64() & ((64'd1 << b) - 64'd1)) | (64'd1 << (b - 1));
	endfunction

	// a * scale / divisor, rounded half up, saturated to 64 bits.
	function automatic logic [TS_W-1:0] scaled_ratio(input logic [63:0] a,
		input logic [63:0] scale, input logic [63:0] divisor);
		logic [127:0] prod, quo, rem, d;
		d    = {64'd0, divisor};
		prod = {64'd0, a} * {64'd0, scale};
		quo  = prod / d;
		rem  = prod % d;
		if (rem >= d - rem) quo = quo + 128'd1;
		return (quo[127:64] != '0) ? '1 : quo[63:0];
	endfunction

	// Advances the histogram state by one transaction; lines land in fresh_lines.
	function automatic void histogram_step(input logic fn, input logic [TS_W-1:0] ts);
		logic [TS_W-1:0] delta, elapsed, mag, pct;
		int slot, top, i;
		report_line_t line;
		fresh_lines.delete();
		line = '0;
		if (fn == FUNC_START) begin
			run_active = 1'b1;
			run_start  = ts;
			prev_ts    = ts;
			loop_total = '0;
			for (i = 0; i < BIN_COUNT; i++) bin_tally[i] = '0;
			return;
		end
		if (!run_active) return;

		delta = ts - prev_ts;
		if (delta[TS_W-1]) begin
			// clock went backwards: report it and drop the run
			mag        = -delta;
			line.kind  = KIND_WARP;
			line.warp  = (mag >= 64'h8000_0000) ? 32'h8000_0000 : delta[WARP_W-1:0];
			line.last  = 1'b1;
			run_active = 1'b0;
			warps_seen++;
			fresh_lines.push_back(line);
			return;
		end

		slot = bit_length(delta);
		if (slot > BIN_COUNT - 1) slot = BIN_COUNT - 1;
		if (bin_tally[slot] != CNT_SAT) bin_tally[slot] = bin_tally[slot] + 1'b1;
		if (loop_total != CNT_SAT) loop_total = loop_total + 1'b1;
		prev_ts = ts;

		// elapsed wraps modulo 2^64 and compares unsigned
		elapsed = ts - run_start;
		if (elapsed < 64'(cfg_duration) * 64'(US_PER_S)) return;

		run_active = 1'b0;
		reports_seen++;
		line.kind     = KIND_SUMMARY;
		line.loops    = loop_total;
		line.per_loop = scaled_ratio(elapsed, 64'(CENTI_NS_PER_US), 64'(loop_total));
		fresh_lines.push_back(line);

		top = -1;
		for (i = BIN_COUNT - 1; i >= 0; i--)
			if (top < 0 && bin_tally[i] != '0) top = i;
		for (i = top; i >= 0; i--) begin
			line = '0;
			pct  = scaled_ratio(64'(bin_tally[i]), 64'(PCT_SCALE), 64'(loop_total));
			if (pct > 64'(PCT_SCALE)) pct = 64'(PCT_SCALE);
			line.kind     = KIND_BIN;
			line.exponent = BIN_W'(i);
			line.count    = bin_tally[i];
			line.pct      = pct[PCT_W-1:0];
			line.last     = (i == 0);
			fresh_lines.push_back(line);
		end
	endfunction

	// Input gap: mostly none or short, now and then long; none in calm stretches.
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_row(input row_mode_t mode, input logic fn,
		input logic [TS_W-1:0] ts, input logic [WARP_W-1:0] warp);
		stim_row_t row;
		row            = '0;
		row.fn         = fn;
		row.ts         = ts;
		row.typed      = (mode != ROW_PREDICT);
		row.has_line   = (mode == ROW_WARP);
		row.line.kind  = KIND_WARP;
		row.line.warp  = warp;
		row.line.last  = 1'b1;
		directed_rows.push_back(row);
	endfunction

	function automatic void check_field(input string label, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, label, want, got);
			mismatch_count++;
		end
	endfunction

	// Drives one input transaction, waits for it to be taken, then records what it owes.
	task automatic send_item(input logic fn, input logic [TS_W-1:0] ts, input logic typed,
		input logic has_line, input report_line_t line);
		int gap;
		gap = pick_gap((item_seq % 40) >= 30);
		item_seq++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= fn;
		timestamp_us <= ts;
		do @(posedge clk); while (!(in_valid && !in_stall));
		histogram_step(fn, ts);
		if (typed) begin
			if (has_line) pending_lines.push_back(line);
		end else begin
			foreach (fresh_lines[i]) pending_lines.push_back(fresh_lines[i]);
		end
	endtask

	// Setup phase, access phase until pready, then the bus returns to idle.
	task automatic apb_transfer(input logic wr, input logic [ADDR_W-1:0] addr,
		input logic [APB_W-1:0] wdata, output logic [APB_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_duration_reg();
		logic [APB_W-1:0] got;
		apb_transfer(1'b0, REG_DURATION, '0, got);
		if (got !== APB_W'(cfg_duration)) begin
			$display("%0t: duration readback mismatch, expected %0d actual %0d",
				$time, cfg_duration, got);
			mismatch_count++;
		end
	endtask

	task automatic set_duration(input logic [DUR_W-1:0] secs);
		logic [APB_W-1:0] ignored;
		apb_transfer(1'b1, REG_DURATION, APB_W'(secs), ignored);
		cfg_duration = secs;
		check_duration_reg();
	endtask

	task automatic wait_for_drain();
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed runs: start, samples with deltas sized to the run length,
	// some warps and restarts; the rest is raw noise and samples while idle.
	task automatic run_random_phase(input logic [DUR_W-1:0] secs);
		int counted, lb, b, r;
		logic fn;
		logic [TS_W-1:0] ts;
		set_duration(secs);
		lb = bit_length(64'(secs) * 64'(US_PER_S));
		counted = 0;
		while (counted < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				fn = 1'($urandom_range(0, 1));
				ts = rand64();
			end else if (!run_active) begin
				if (r < 16) begin
					fn = FUNC_SAMPLE;
					ts = rand64();
				end else begin
					fn = FUNC_START;
					// sometimes just below the top so elapsed time wraps
					ts = ($urandom_range(0, 4) == 0) ? ~64'($urandom)
						: rand64() >> $urandom_range(0, 63);
				end
			end else if (r < 12) begin
				fn = FUNC_START;
				ts = rand64() >> $urandom_range(0, 63);
			end else if (r < 20) begin
				fn = FUNC_SAMPLE;
				ts = prev_ts - sized_value($urandom_range(1, 40));
			end else begin
				fn = FUNC_SAMPLE;
				r  = $urandom_range(0, 99);
				if (r < 60) b = $urandom_range(lb > 4 ? lb - 4 : 0, lb);
				else if (r < 95) b = $urandom_range(0, lb + 1);
				else b = $urandom_range(32, 63);
				ts = prev_ts + sized_value(b);
			end
			counted++;
			send_item(fn, ts, 1'b0, 1'b0, '0);
		end
		in_valid <= 1'b0;
		wait_for_drain();
	endtask

	// Output stall pattern: short and long stalls, with stall-free windows.
	always @(posedge clk) begin : stall_pattern
		int r;
		stall_tick++;
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ((stall_tick / 1500) % 4 == 3) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				out_stall <= 1'b0;
			end else if (r < 95) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				stall_left = $urandom_range(10, 60);
				out_stall <= 1'b1;
			end
		end
	end

	// Result transactions against the oldest owed line.
	always @(posedge clk) begin : line_checker
		report_line_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lines.size() == 0) begin
				$display("%0t: unexpected result transaction, kind %0d", $time, kind);
				mismatch_count++;
			end else begin
				want = pending_lines.pop_front();
				check_field("kind", 64'(want.kind), 64'(kind));
				check_field("warp_us", 64'(want.warp), 64'(warp_us));
				check_field("total_loops", 64'(want.loops), 64'(total_loops));
				check_field("per_loop_centi_ns", want.per_loop, per_loop_centi_ns);
				check_field("bin_exponent", 64'(want.exponent), 64'(bin_exponent));
				check_field("bin_count", 64'(want.count), 64'(bin_count));
				check_field("percent_e5", 64'(want.pct), 64'(percent_e5));
				check_field("last", 64'(want.last), 64'(last));
				lines_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d lines still owed", $time, pending_lines.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_duration_reg();  // reset value

		// Directed rows, duration at its reset value of 3 s.
		add_row(ROW_SILENT, FUNC_SAMPLE, 64'd5, '0);                       // sample while idle
		add_row(ROW_PREDICT, FUNC_START, 64'd0, '0);
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'd0, '0);                      // zero delta, bin 0
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'd1, '0);
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'd3, '0);
		add_row(ROW_WARP, FUNC_SAMPLE, 64'd2, 32'hFFFF_FFFF);               // delta of -1
		add_row(ROW_PREDICT, FUNC_START, 64'd100, '0);
		add_row(ROW_WARP, FUNC_SAMPLE, 64'hFFFF_FFFF_8000_0064, 32'h8000_0000); // exactly -2^31
		add_row(ROW_PREDICT, FUNC_START, 64'h8000_0000, '0);
		add_row(ROW_WARP, FUNC_SAMPLE, 64'd1, 32'h8000_0001);              // -(2^31 - 1)
		add_row(ROW_PREDICT, FUNC_START, 64'd0, '0);
		add_row(ROW_WARP, FUNC_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF); // top timestamp
		add_row(ROW_PREDICT, FUNC_START, 64'hFFFF_FFFF_FFFF_FFF0, '0);
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, '0);
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'd2, '0);                      // wraps past zero
		add_row(ROW_PREDICT, FUNC_START, 64'd10, '0);                      // restart mid-run
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'd1010, '0);
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'd3_000_009, '0);              // one us short
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'd3_000_010, '0);              // run ends
		add_row(ROW_SILENT, FUNC_SAMPLE, 64'd3_000_020, '0);               // idle again
		add_row(ROW_PREDICT, FUNC_START, 64'd0, '0);
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'h0000_0100_0000_0000, '0);    // bit length above 31, 33 lines
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF, '0);    // run over, ignored
		add_row(ROW_PREDICT, FUNC_START, 64'd0, '0);
		add_row(ROW_PREDICT, FUNC_SAMPLE, 64'h4000_0000_0000_0000, '0);    // per-loop saturates
		foreach (directed_rows[i])
			send_item(directed_rows[i].fn, directed_rows[i].ts, directed_rows[i].typed,
				directed_rows[i].has_line, directed_rows[i].line);
		in_valid <= 1'b0;
		wait_for_drain();

		// Random phases over several run lengths, zero and the 12-bit maximum among them.
		run_random_phase(12'd1);
		run_random_phase(12'd0);
		run_random_phase(12'd4095);
		run_random_phase(DUR_W'($urandom_range(4, 3600)));
		run_random_phase(12'd2);

		$display("Sent %0d input transactions over six run lengths (0 s to 4095 s).", item_seq);
		$display("Checked %0d result transactions: %0d run reports, %0d time warps.",
			lines_checked, reports_seen, warps_seen);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
